// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL files.
// Included by the top level only; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock edge, disabled while in reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- src/slsl_pkg.sv -----
// Shared constants and types for the single-layer segment length block.
// No dependencies.
package slsl_pkg;
	localparam int unsigned MaxSegmentsDef = 1024;
	localparam int unsigned CoordBitsDef = 32;
	localparam int unsigned FieldBits = 32;

	// Sweep accumulator: 64 bits, like the model's internal sums.
	localparam int unsigned SumBits = 64;

	// Memory request from sequencer to store.
	typedef struct packed {
		logic        we;
		logic [16:0] addr;
	} mem_ctl_t;
endpackage

// ----- src/slsl_store.sv -----
// Segment store: one synchronous memory, one write or one read per cycle,
// read data registered. Depends on slsl_pkg.
module slsl_store import slsl_pkg::*; #(
	parameter int unsigned MAX_SEGMENTS = MaxSegmentsDef,
	parameter int unsigned COORD_BITS = CoordBitsDef,
	localparam int unsigned AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [AW-1:0]                addr,
	input  logic [2*COORD_BITS-1:0]      wdata,
	output logic [2*COORD_BITS-1:0]      rdata
);
	logic [2*COORD_BITS-1:0] mem_q [MAX_SEGMENTS];

	// Write or read at one address each cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// ----- src/slsl_seq.sv -----
// Load, heap-sort and sweep sequencer for the segment store.
// Depends on slsl_pkg; drives slsl_store.
module slsl_seq import slsl_pkg::*; #(
	parameter int unsigned MAX_SEGMENTS = MaxSegmentsDef,
	parameter int unsigned COORD_BITS = CoordBitsDef,
	localparam int unsigned AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1,
	localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [FieldBits-1:0]    seg_start,
	input  logic [FieldBits-1:0]    seg_end,
	input  logic                    last_segment,
	input  logic                    in_valid,
	output logic                    in_ready,
	output logic [FieldBits-1:0]    single_cover_length,
	output logic                    capacity_overflow,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    mem_we,
	output logic [AW-1:0]           mem_addr,
	output logic [2*COORD_BITS-1:0] mem_wdata,
	input  logic [2*COORD_BITS-1:0] mem_rdata
);
	typedef enum logic [3:0] {
		ST_LOAD, ST_HEAP_NEXT, ST_RD_ROOT, ST_RD_C1, ST_RD_C2, ST_CMP,
		ST_WR_ROOT, ST_WR_CHILD, ST_EX_RD0, ST_EX_RD1, ST_EX_WR0, ST_EX_WR1,
		ST_SW_RD, ST_SW_STEP, ST_DONE
	} state_t;

	typedef logic signed [COORD_BITS-1:0] crd_t;

	state_t               state_q;
	logic [CW-1:0]        count_q;
	logic                 ovf_q;
	logic [CW-1:0]        build_q;   // next heapify root + 1
	logic [CW-1:0]        heapn_q;   // current heap size
	logic                 extract_q; // in extraction phase
	logic [CW:0]          root_q;
	logic [CW:0]          child_q;
	logic [2*COORD_BITS-1:0] root_d_q, c1_d_q, c2_d_q, pick_d;
	logic                 has_c2_q;
	logic [CW-1:0]        sw_idx_q;
	logic signed [COORD_BITS:0] ps_q, pe_q;
	logic [SumBits-1:0]   total_q;
	logic [FieldBits-1:0] len_q;
	logic                 ovf_out_q;
	logic                 out_valid_q;

	crd_t a_c, b_c, ts, te;
	logic [CW:0] c1_idx, c2_idx;
	logic pick2, swap_need;
	logic signed [COORD_BITS:0] ts_c, te_c;

	// a sorts after b
	function automatic logic after_f(input logic [2*COORD_BITS-1:0] a,
		input logic [2*COORD_BITS-1:0] b);
		crd_t al, ah, bl, bh;
		al = a[2*COORD_BITS-1:COORD_BITS];
		ah = a[COORD_BITS-1:0];
		bl = b[2*COORD_BITS-1:COORD_BITS];
		bh = b[COORD_BITS-1:0];
		if (al != bl) return al > bl;
		return ah < bh;
	endfunction

	// Narrow and order the incoming endpoints.
	assign a_c = crd_t'(seg_start[COORD_BITS-1:0]);
	assign b_c = crd_t'(seg_end[COORD_BITS-1:0]);
	assign c1_idx = {root_q[CW-1:0], 1'b1};
	assign c2_idx = c1_idx + (CW+1)'(1);
	assign pick2 = has_c2_q && after_f(c2_d_q, c1_d_q);
	assign pick_d = pick2 ? c2_d_q : c1_d_q;
	assign swap_need = after_f(pick_d, root_d_q);

	// Sweep clipping of the segment just read.
	assign ts = crd_t'(mem_rdata[2*COORD_BITS-1:COORD_BITS]);
	assign te = crd_t'(mem_rdata[COORD_BITS-1:0]);
	assign ts_c = ($signed({ts[COORD_BITS-1], ts}) < ps_q) ? ps_q : {ts[COORD_BITS-1], ts};
	assign te_c = {te[COORD_BITS-1], te};

	// Result register parts the input from a waiting result.
	assign in_ready = (state_q == ST_LOAD);
	assign out_valid = out_valid_q;
	assign single_cover_length = len_q;
	assign capacity_overflow = ovf_out_q;

	// Memory port control.
	always_comb begin
		mem_we = 1'b0;
		mem_addr = '0;
		mem_wdata = root_d_q;
		case (state_q)
			ST_LOAD: begin
				mem_addr = count_q[AW-1:0];
				mem_wdata = (a_c < b_c) ? {a_c, b_c} : {b_c, a_c};
				mem_we = in_valid && in_ready && (count_q < CW'(MAX_SEGMENTS));
			end
			ST_RD_ROOT: mem_addr = root_q[AW-1:0];
			ST_RD_C1:   mem_addr = c1_idx[AW-1:0];
			ST_RD_C2:   mem_addr = c2_idx[AW-1:0];
			ST_WR_ROOT: begin
				mem_we = swap_need;
				mem_addr = root_q[AW-1:0];
				mem_wdata = pick_d;
			end
			ST_WR_CHILD: begin
				mem_we = 1'b1;
				mem_addr = child_q[AW-1:0];
				mem_wdata = root_d_q;
			end
			ST_EX_RD0: mem_addr = '0;
			ST_EX_RD1: mem_addr = AW'(heapn_q - CW'(1));
			ST_EX_WR0: begin
				mem_we = 1'b1;
				mem_addr = '0;
				mem_wdata = mem_rdata;
			end
			// old top goes to the slot just freed at the heap's end
			ST_EX_WR1: begin
				mem_we = 1'b1;
				mem_addr = heapn_q[AW-1:0];
				mem_wdata = root_d_q;
			end
			ST_SW_RD:   mem_addr = sw_idx_q[AW-1:0];
			default: ;
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			ovf_q <= 1'b0;
			out_valid_q <= 1'b0;
			extract_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_LOAD: begin
					if (in_valid && in_ready) begin
						if (count_q < CW'(MAX_SEGMENTS)) count_q <= count_q + CW'(1);
						else ovf_q <= 1'b1;
						if (last_segment) begin
							heapn_q <= (count_q < CW'(MAX_SEGMENTS)) ? count_q + CW'(1)
								: count_q;
							build_q <= ((count_q < CW'(MAX_SEGMENTS)) ? count_q + CW'(1)
								: count_q) >> 1;
							extract_q <= 1'b0;
							state_q <= ST_HEAP_NEXT;
						end
					end
				end
				ST_HEAP_NEXT: begin
					if (!extract_q && build_q != '0) begin
						root_q <= {1'b0, build_q - CW'(1)};
						build_q <= build_q - CW'(1);
						state_q <= ST_RD_ROOT;
					end else if (heapn_q > CW'(1)) begin
						extract_q <= 1'b1;
						state_q <= ST_EX_RD0;
					end else begin
						sw_idx_q <= '0;
						total_q <= '0;
						state_q <= ST_SW_RD;
					end
				end
				ST_RD_ROOT: begin
					if (c1_idx >= {1'b0, heapn_q}) state_q <= ST_HEAP_NEXT;
					else state_q <= ST_RD_C1;
				end
				ST_RD_C1: begin
					root_d_q <= mem_rdata;
					has_c2_q <= c2_idx < {1'b0, heapn_q};
					state_q <= ST_RD_C2;
				end
				ST_RD_C2: begin
					c1_d_q <= mem_rdata;
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					c2_d_q <= mem_rdata;
					state_q <= ST_WR_ROOT;
				end
				ST_WR_ROOT: begin
					if (swap_need) begin
						child_q <= pick2 ? c2_idx : c1_idx;
						state_q <= ST_WR_CHILD;
					end else begin
						state_q <= ST_HEAP_NEXT;
					end
				end
				ST_WR_CHILD: begin
					root_q <= child_q;
					state_q <= ST_RD_ROOT;
				end
				ST_EX_RD0: state_q <= ST_EX_RD1;
				ST_EX_RD1: begin
					root_d_q <= mem_rdata;
					state_q <= ST_EX_WR0;
				end
				ST_EX_WR0: begin
					heapn_q <= heapn_q - CW'(1);
					state_q <= ST_EX_WR1;
				end
				// sift the new top down over the shrunken heap
				ST_EX_WR1: begin
					root_q <= '0;
					state_q <= ST_RD_ROOT;
				end
				ST_SW_RD: state_q <= ST_SW_STEP;
				ST_SW_STEP: begin
					if (sw_idx_q == '0) begin
						ps_q <= {ts[COORD_BITS-1], ts};
						pe_q <= te_c;
					end else if (te_c < ps_q) begin
					end else if (ts_c < pe_q) begin
						total_q <= total_q + SumBits'(ts_c - ps_q);
						if (te_c > pe_q) begin
							ps_q <= pe_q;
							pe_q <= te_c;
						end else begin
							ps_q <= te_c;
						end
					end else begin
						total_q <= total_q + SumBits'(pe_q - ps_q);
						ps_q <= ts_c;
						pe_q <= te_c;
					end
					if (sw_idx_q + CW'(1) < count_q) begin
						sw_idx_q <= sw_idx_q + CW'(1);
						state_q <= ST_SW_RD;
					end else begin
						state_q <= ST_DONE;
					end
				end
				// wait for the previous result to leave
				ST_DONE: begin
					if (!out_valid_q) begin
						len_q <= FieldBits'(total_q + SumBits'(pe_q - ps_q));
						ovf_out_q <= ovf_q;
						out_valid_q <= 1'b1;
						count_q <= '0;
						ovf_q <= 1'b0;
						state_q <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end
endmodule

// ----- src/single_layer_segment_length_top.sv -----
// Top level of the single-layer segment length block.
// Depends on slsl_pkg, slsl_seq, slsl_store and assert_macros.svh.
// Segments load one per cycle, while in_ready is high, into a single-port
// store. The item marked last starts an in-place heap sort, then a sweep
// that reads each segment (ST_SW_RD) and then folds it in (ST_SW_STEP);
// each sift level makes its reads and writes one at a time on the one store port.
// Items beyond MAX_SEGMENTS are dropped and flagged in the result.
`include "assert_macros.svh"
module single_layer_segment_length_top import slsl_pkg::*; #(
	parameter int unsigned MAX_SEGMENTS = MaxSegmentsDef,
	parameter int unsigned COORD_BITS = CoordBitsDef
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic signed [FieldBits-1:0] seg_start,
	input  logic signed [FieldBits-1:0] seg_end,
	input  logic                        last_segment,
	input  logic                        in_valid,
	output logic                        in_ready,
	output logic [FieldBits-1:0]        single_cover_length,
	output logic                        capacity_overflow,
	output logic                        out_valid,
	input  logic                        out_ready
);
	localparam int unsigned AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

	logic                    mem_we;
	logic [AW-1:0]           mem_addr;
	logic [2*COORD_BITS-1:0] mem_wdata, mem_rdata;

	slsl_seq #(.MAX_SEGMENTS(MAX_SEGMENTS), .COORD_BITS(COORD_BITS)) u_seq (
		.clk, .arst_n, .seg_start, .seg_end, .last_segment, .in_valid, .in_ready,
		.single_cover_length, .capacity_overflow, .out_valid, .out_ready,
		.mem_we, .mem_addr, .mem_wdata, .mem_rdata
	);

	slsl_store #(.MAX_SEGMENTS(MAX_SEGMENTS), .COORD_BITS(COORD_BITS)) u_store (
		.clk, .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
	);

	`ASSERT_NEXT(a_last_blocks, clk, arst_n, in_valid && in_ready && last_segment, !in_ready)
	`ASSERT_NEXT(a_len_holds, clk, arst_n, out_valid && !out_ready, $stable(single_cover_length))
	`ASSERT_NEXT(a_out_holds, clk, arst_n, out_valid && !out_ready, out_valid)
endmodule

// ----- test/tb_single_layer_segment_length_top.sv -----
// Testbench for single_layer_segment_length_top: directed and random segment sets.
// Depends on slsl_pkg and the block's RTL; a local predictor computes each set's length.
`timescale 1ns / 100ps
module tb_single_layer_segment_length_top;
	import slsl_pkg::*;

	typedef struct {
		logic [FieldBits-1:0] length;
		logic                 dropped;
	} set_result_t;

	logic                        clk;
	logic                        arst_n;
	logic signed [FieldBits-1:0] seg_start;
	logic signed [FieldBits-1:0] seg_end;
	logic                        last_segment;
	logic                        in_valid;
	logic                        in_ready;
	logic [FieldBits-1:0]        single_cover_length;
	logic                        capacity_overflow;
	logic                        out_valid;
	logic                        out_ready;

	single_layer_segment_length_top dut (
		.clk(clk), .arst_n(arst_n), .seg_start(seg_start), .seg_end(seg_end),
		.last_segment(last_segment), .in_valid(in_valid), .in_ready(in_ready),
		.single_cover_length(single_cover_length), .capacity_overflow(capacity_overflow),
		.out_valid(out_valid), .out_ready(out_ready)
	);

	// Predictor state: segments of the current set, in arrival order
	longint      set_lo[$];
	longint      set_hi[$];
	bit          set_dropped;
	set_result_t pending_lengths[$];
	int          fail_count;
	int          sets_sent;
	int          items_sent;
	int          idle_pct;
	int          stall_pct;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Mismatches found");
		$finish;
	end

	// true when (a_lo, a_hi) goes after (b_lo, b_hi) in sweep order
	function automatic bit goes_after(longint a_lo, longint a_hi, longint b_lo, longint b_hi);
		if (a_lo != b_lo) return a_lo > b_lo;
		return a_hi < b_hi;
	endfunction

	// Sort by start (longer first on ties), then sum the once-covered length
	function automatic longint once_covered_length();
		longint lo[$];
		longint hi[$];
		longint k_lo, k_hi, ps, pe, ts, te, total;
		int     j;
		lo = set_lo;
		hi = set_hi;
		total = 0;
		if (lo.size() == 0) return 0;
		for (int i = 1; i < lo.size(); i++) begin
			k_lo = lo[i];
			k_hi = hi[i];
			j = i;
			while (j > 0 && goes_after(lo[j-1], hi[j-1], k_lo, k_hi)) begin
				lo[j] = lo[j-1];
				hi[j] = hi[j-1];
				j--;
			end
			lo[j] = k_lo;
			hi[j] = k_hi;
		end
		ps = lo[0];
		pe = hi[0];
		for (int i = 1; i < lo.size(); i++) begin
			ts = (lo[i] < ps) ? ps : lo[i];
			te = hi[i];
			if (te < ps) continue;
			if (ts < pe) begin
				total += ts - ps;
				if (te > pe) begin
					ps = pe;
					pe = te;
				end else begin
					ps = te;
				end
			end else begin
				total += pe - ps;
				ps = ts;
				pe = te;
			end
		end
		return total + pe - ps;
	endfunction

	// Update the predictor with one accepted item
	function automatic void absorb_segment(logic signed [FieldBits-1:0] a,
			logic signed [FieldBits-1:0] b, logic last);
		set_result_t r;
		longint la, lb;
		la = longint'(a);
		lb = longint'(b);
		if (set_lo.size() < MaxSegmentsDef) begin
			set_lo.insert(set_lo.size(), la < lb ? la : lb);
			set_hi.insert(set_hi.size(), la < lb ? lb : la);
		end else begin
			set_dropped = 1'b1;
		end
		if (last) begin
			r.length = once_covered_length();
			r.dropped = set_dropped;
			pending_lengths.insert(pending_lengths.size(), r);
			set_lo.delete();
			set_hi.delete();
			set_dropped = 1'b0;
			sets_sent++;
		end
	endfunction

	// Send one item, with random idle cycles ahead of it
	task automatic send_item(logic signed [FieldBits-1:0] a, logic signed [FieldBits-1:0] b,
			logic last);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		seg_start <= a;
		seg_end <= b;
		last_segment <= last;
		do @(posedge clk); while (!in_ready);
		absorb_segment(a, b, last);
		items_sent++;
	endtask

	// Hold the sender until every expected result is in
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_lengths.size() != 0) @(posedge clk);
	endtask

	// Receiver stalls
	always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

	// Result checker
	always @(posedge clk) begin
		set_result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (pending_lengths.size() == 0) begin
				$error("result with no expectation: single_cover_length %0d", single_cover_length);
				fail_count++;
			end else begin
				exp_r = pending_lengths.pop_front();
				if (single_cover_length !== exp_r.length) begin
					$error("single_cover_length expected %0d actual %0d", exp_r.length,
						single_cover_length);
					fail_count++;
				end
				if (capacity_overflow !== exp_r.dropped) begin
					$error("capacity_overflow expected %0b actual %0b", exp_r.dropped,
						capacity_overflow);
					fail_count++;
				end
			end
		end
	end

	// Extremes, reversed endpoints and typical overlap shapes
	task automatic test_directed();
		send_item(32'sh8000_0000, 32'sh7fff_ffff, 1'b1);   // full span
		send_item(32'sh7fff_ffff, 32'sh8000_0000, 1'b1);   // full span, reversed
		send_item(5, 5, 1'b1);                              // zero length
		send_item(10, 20, 1'b0);                            // identical pair
		send_item(20, 10, 1'b1);
		send_item(0, 100, 1'b0);                            // nested
		send_item(30, 60, 1'b1);
		send_item(0, 10, 1'b0);                             // equal starts
		send_item(0, 40, 1'b0);
		send_item(0, 25, 1'b1);
		send_item(-50, -20, 1'b0);                          // touching, disjoint
		send_item(-20, 0, 1'b0);
		send_item(100, 300, 1'b1);
		send_item(32'sh8000_0000, 32'sh8000_0000, 1'b0);    // extreme points
		send_item(32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0);
		send_item(-1, 0, 1'b1);
		send_item(90, 10, 1'b0);                            // staggered overlaps
		send_item(50, 120, 1'b0);
		send_item(110, 115, 1'b0);
		send_item(-1, -1, 1'b1);
		wait_drained();
	endtask

	// Fill the store past capacity; the last item itself is dropped too
	task automatic test_store_full();
		for (int i = 0; i < MaxSegmentsDef + 1; i++)
			send_item($urandom_range(2000) - 1000, $urandom_range(2000) - 1000, 1'b0);
		send_item(0, 7, 1'b1);
		wait_drained();
	endtask

	// Random sets: mostly small coordinates so segments overlap, some full range
	task automatic test_random_sets(int n_items);
		int target, len, span;
		logic signed [FieldBits-1:0] a, b;
		target = items_sent + n_items;
		while (items_sent < target) begin
			len = ($urandom_range(19) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
			span = ($urandom_range(3) == 0) ? 0 : $urandom_range(1000, 8);
			for (int i = 0; i < len; i++) begin
				if (span == 0) begin
					a = $urandom;
					b = $urandom;
				end else begin
					a = $urandom_range(span) - span / 2;
					b = a + $urandom_range(span / 2);
					if ($urandom_range(1)) begin
						a = a ^ b;
						b = a ^ b;
						a = a ^ b;
					end
				end
				send_item(a, b, i == len - 1);
			end
		end
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		seg_start = '0;
		seg_end = '0;
		last_segment = 1'b0;
		out_ready = 1'b0;
		fail_count = 0;
		sets_sent = 0;
		items_sent = 0;
		idle_pct = 0;
		stall_pct = 0;
		set_dropped = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_store_full();
		idle_pct = 0;  stall_pct = 0;  test_random_sets(60);
		idle_pct = 72; stall_pct = 0;  test_random_sets(60);
		idle_pct = 0;  stall_pct = 72; test_random_sets(60);
		idle_pct = 14; stall_pct = 14; test_random_sets(60);

		repeat (20) @(posedge clk);
		$display("Covered %0d items in %0d segment sets, incl. a store overflow set,",
			items_sent, sets_sent);
		$display("full-range and reversed endpoints, under varied idle and stall rates.");
		if (fail_count == 0 && pending_lengths.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
